// ===== hw/rtl/bcd_pkg.sv =====
// Shared types and constants for the BC1/BC2/BC3 block decoder.
// No dependencies; imported by every module of the decoder.
package bcd_pkg;

    localparam int MAX_DIMENSION = 4096;
    localparam int DIM_W         = 13;  // holds 1..MAX_DIMENSION
    localparam int POS_W         = 10;  // block column / row
    localparam int LANES         = 16;  // pixels per 4x4 block

    typedef enum logic [1:0] {
        CODEC_BC1 = 2'd0,
        CODEC_BC2 = 2'd1,
        CODEC_BC3 = 2'd2
    } codec_t;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_CODEC  = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    typedef struct packed {
        logic [63:0] color_data;
        logic [63:0] alpha_block;
    } block_t;

    typedef struct packed {
        logic [11:0] pixel_x;
        logic [11:0] pixel_y;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic        last_of_block;
        logic        last_of_image;
        logic        alpha_seen;
    } pixel_t;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } rgb_t;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] a;
    } rgba_t;

    // per-block control carried down the pipeline
    typedef struct packed {
        logic [POS_W-1:0] col;
        logic [POS_W-1:0] row;
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        codec_t           codec;
        logic             final_blk;  // last block position of the image
        logic             wrap;       // position wraps to start: clear sticky flag
    } block_meta_t;

endpackage

// ===== hw/rtl/bcd_cfg_regs.sv =====
// APB-style configuration registers: codec, image width, image height.
// Depends on bcd_pkg.
module bcd_cfg_regs
    import bcd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output logic [1:0]        codec,
    output logic [DIM_W-1:0]  image_width,
    output logic [DIM_W-1:0]  image_height
);

    logic [1:0]       codec_reg;
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            codec_reg  <= CODEC_BC1;
            width_reg  <= DIM_W'(1);
            height_reg <= DIM_W'(1);
        end
        else if (wr_en)
        begin
            unique case (paddr[3:2])
                REG_CODEC:  codec_reg  <= pwdata[1:0];
                REG_WIDTH:  width_reg  <= pwdata[DIM_W-1:0];
                REG_HEIGHT: height_reg <= pwdata[DIM_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_CODEC:  prdata = {30'd0, codec_reg};
            REG_WIDTH:  prdata = {{(32-DIM_W){1'b0}}, width_reg};
            REG_HEIGHT: prdata = {{(32-DIM_W){1'b0}}, height_reg};
            default:    prdata = 32'd0;
        endcase
    end

    assign codec        = codec_reg;
    assign image_width  = width_reg;
    assign image_height = height_reg;

endmodule

// ===== hw/rtl/bcd_palette.sv =====
// Per-block palette builder: registers the interpolation numerators, then
// divides by 3, 5 or 7 with reciprocal multiplies. Depends on bcd_pkg.
module bcd_palette
    import bcd_pkg::*;
(
    input  logic            clk,
    input  logic            load,
    input  block_t          blk,
    input  codec_t          codec,
    output rgb_t [3:0]      cpal,
    output logic            punch,
    output logic [7:0][7:0] apal
);

    // floor(n/3) for n <= 765, floor(n/5) for n < 1280, floor(n/7) for n < 1792
    localparam logic [9:0]  RECIP3 = 10'd683;   // 2^11 / 3
    localparam logic [11:0] RECIP5 = 12'd3277;  // 2^14 / 5
    localparam logic [11:0] RECIP7 = 12'd2341;  // 2^14 / 7

    function automatic logic [7:0] div3(input logic [9:0] n);
        logic [19:0] p;
        p = n * RECIP3;
        return p[18:11];
    endfunction

    function automatic logic [7:0] div5(input logic [10:0] n);
        logic [22:0] p;
        p = n * RECIP5;
        return p[21:14];
    endfunction

    function automatic logic [7:0] div7(input logic [10:0] n);
        logic [22:0] p;
        p = n * RECIP7;
        return p[21:14];
    endfunction

    function automatic rgb_t expand565(input logic [15:0] c);
        rgb_t o;
        o.r = {c[15:11], c[15:13]};
        o.g = {c[10:5], c[10:9]};
        o.b = {c[4:0], c[4:2]};
        return o;
    endfunction

    logic [15:0]     c0;
    logic [15:0]     c1;
    rgb_t            e0;
    rgb_t            e1;
    logic [7:0]      a0;
    logic [7:0]      a1;
    logic [2:0][9:0] n2_d;
    logic [2:0][9:0] n3_d;
    rgb_t            half_d;
    logic [5:0][10:0] an_d;

    rgb_t            e0_reg;
    rgb_t            e1_reg;
    rgb_t            half_reg;
    logic [2:0][9:0] n2_reg;
    logic [2:0][9:0] n3_reg;
    logic            punch_reg;
    logic [7:0]      a0_reg;
    logic [7:0]      a1_reg;
    logic            amode_reg;   // a0 > a1: eight-entry palette
    logic [5:0][10:0] an_reg;

    logic [2:0][7:0] ch0;
    logic [2:0][7:0] ch1;
    logic [8:0]      hsum;

    assign c0 = blk.color_data[15:0];
    assign c1 = blk.color_data[31:16];
    assign e0 = expand565(c0);
    assign e1 = expand565(c1);
    assign a0 = blk.alpha_block[7:0];
    assign a1 = blk.alpha_block[15:8];
    assign ch0 = {e0.r, e0.g, e0.b};
    assign ch1 = {e1.r, e1.g, e1.b};

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            n2_d[k] = {1'b0, ch0[k], 1'b0} + {2'b00, ch1[k]};
            n3_d[k] = {2'b00, ch0[k]} + {1'b0, ch1[k], 1'b0};
        end
        hsum = {1'b0, e0.r} + {1'b0, e1.r};
        half_d.r = hsum[8:1];
        hsum = {1'b0, e0.g} + {1'b0, e1.g};
        half_d.g = hsum[8:1];
        hsum = {1'b0, e0.b} + {1'b0, e1.b};
        half_d.b = hsum[8:1];
        for (int k = 1; k <= 6; k++)
        begin
            if (a0 > a1)
                an_d[k-1] = 11'((7 - k) * a0 + k * a1 + 3);
            else if (k <= 4)
                an_d[k-1] = 11'((5 - k) * a0 + k * a1 + 2);
            else
                an_d[k-1] = 11'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            e0_reg    <= e0;
            e1_reg    <= e1;
            half_reg  <= half_d;
            n2_reg    <= n2_d;
            n3_reg    <= n3_d;
            punch_reg <= (codec == CODEC_BC1) && (c0 <= c1);
            a0_reg    <= a0;
            a1_reg    <= a1;
            amode_reg <= a0 > a1;
            an_reg    <= an_d;
        end
    end

    always_comb
    begin
        cpal[0] = e0_reg;
        cpal[1] = e1_reg;
        if (punch_reg)
        begin
            cpal[2] = half_reg;
            cpal[3] = '0;
        end
        else
        begin
            cpal[2] = '{r: div3(n2_reg[2]), g: div3(n2_reg[1]), b: div3(n2_reg[0])};
            cpal[3] = '{r: div3(n3_reg[2]), g: div3(n3_reg[1]), b: div3(n3_reg[0])};
        end

        apal[0] = a0_reg;
        apal[1] = a1_reg;
        for (int k = 0; k < 6; k++)
            apal[k+2] = amode_reg ? div7(an_reg[k]) : div5(an_reg[k]);
        if (!amode_reg)
        begin
            apal[6] = 8'h00;
            apal[7] = 8'hff;
        end
    end

    assign punch = punch_reg;

endmodule

// ===== hw/rtl/bcd_lane.sv =====
// One pixel lane: picks color and alpha from the block palettes by the
// pixel's indices and flags whether it lies inside the image. Uses bcd_pkg.
module bcd_lane
    import bcd_pkg::*;
(
    input  logic [3:0]      lane_idx,
    input  block_meta_t     meta,
    input  rgb_t [3:0]      cpal,
    input  logic            punch,
    input  logic [7:0][7:0] apal,
    input  logic [1:0]      cidx,
    input  logic [3:0]      nib,
    input  logic [2:0]      aidx,
    output rgba_t           px,
    output logic            in_image
);

    logic [11:0] x;
    logic [11:0] y;

    assign x = {meta.col, lane_idx[1:0]};
    assign y = {meta.row, lane_idx[3:2]};
    assign in_image = ({1'b0, x} < meta.width) && ({1'b0, y} < meta.height);

    always_comb
    begin
        px.r = cpal[cidx].r;
        px.g = cpal[cidx].g;
        px.b = cpal[cidx].b;
        unique case (meta.codec)
            CODEC_BC1: px.a = (punch && cidx == 2'd3) ? 8'h00 : 8'hff;
            CODEC_BC2: px.a = {nib, nib};
            default:   px.a = apal[aidx];
        endcase
    end

endmodule

// ===== hw/rtl/bcd_emitter.sv =====
// Merge stage: holds the sixteen lane results of one block and hands out the in-image
// pixels one per cycle when not stalled, via an output register. Uses bcd_pkg.
module bcd_emitter
    import bcd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load_valid,
    output logic              load_ready,
    input  block_meta_t       load_meta,
    input  rgba_t [LANES-1:0] load_px,
    input  logic [LANES-1:0]  load_mask,
    output logic              pix_valid,
    input  logic              pix_stall,
    output pixel_t            pix
);

    logic              busy_reg;
    logic              busy_next;
    logic [LANES-1:0]  mask_reg;
    logic [LANES-1:0]  mask_next;
    rgba_t [LANES-1:0] px_reg;
    block_meta_t       meta_reg;
    logic              flag_reg;
    logic              flag_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    pixel_t            out_reg;
    pixel_t            out_next;

    logic [3:0]        sel;
    logic              found;
    logic [LANES-1:0]  rest;
    logic              last;
    logic              go;
    logic              emit;
    logic              done;
    logic              seen;
    logic              load;
    rgba_t             cur;

    // lowest pending pixel in raster order
    always_comb
    begin
        sel   = 4'd0;
        found = 1'b0;
        for (int i = 0; i < LANES; i++)
        begin
            if (mask_reg[i] && !found)
            begin
                sel   = 4'(i);
                found = 1'b1;
            end
        end
    end

    always_comb
    begin
        rest = mask_reg;
        rest[sel] = 1'b0;
    end

    assign cur        = px_reg[sel];
    assign last       = (rest == '0);
    assign go         = busy_reg && (!out_valid_reg || !pix_stall);
    assign emit       = go && found;
    assign done       = go && last;          // empty blocks retire without emitting a pixel
    assign load_ready = !busy_reg || done;
    assign load       = load_valid && load_ready;
    assign seen       = flag_reg || (cur.a != 8'hff);

    always_comb
    begin
        busy_next = busy_reg;
        mask_next = mask_reg;
        if (emit)
            mask_next = rest;
        if (done)
            busy_next = 1'b0;
        if (load)
        begin
            busy_next = 1'b1;
            mask_next = load_mask;
        end

        flag_next = flag_reg;
        if (emit)
            flag_next = seen;
        if (done && meta_reg.wrap)
            flag_next = 1'b0;

        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (emit)
        begin
            out_valid_next         = 1'b1;
            out_next.pixel_x       = {meta_reg.col, sel[1:0]};
            out_next.pixel_y       = {meta_reg.row, sel[3:2]};
            out_next.red           = cur.r;
            out_next.green         = cur.g;
            out_next.blue          = cur.b;
            out_next.alpha         = cur.a;
            out_next.last_of_block = last;
            out_next.last_of_image = last && meta_reg.final_blk;
            out_next.alpha_seen    = seen;
        end
        else if (!pix_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            mask_reg      <= '0;
            flag_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            mask_reg      <= mask_next;
            flag_reg      <= flag_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        if (load)
        begin
            px_reg   <= load_px;
            meta_reg <= load_meta;
        end
    end

    assign pix_valid = out_valid_reg;
    assign pix       = out_reg;

endmodule

// ===== hw/rtl/bc1_bc2_bc3_block_decoder.sv =====
// BC1/BC2/BC3 block decoder, top level: one 4x4 block per transfer in,
// one RGBA8 pixel per transfer out, in raster order within the block.
// A block's first pixel goes through the stage 1 register, the stage 2 and palette
// registers, the emitter's block registers and its output register. Throughput:
// one pixel per cycle while pix_stall is low; an empty block still takes the emitter.
// Reset (rst_n, async, active low): block position 0,0, sticky flag clear,
// codec BC1, width and height 1, pipeline empty.
module bc1_bc2_bc3_block_decoder
    import bcd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // block input channel
    input  logic        blk_valid,
    output logic        blk_stall,
    input  block_t      blk,
    // pixel output channel
    output logic        pix_valid,
    input  logic        pix_stall,
    output pixel_t      pix,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Pipeline:
    //   stage 1  captured block plus its position / clipping info
    //   stage 2  palette numerators registered, divides + 16 lanes select
    //   stage 3  emitter walks the in-image pixels one per cycle unless stalled
    // Each stage loads when it is empty or its content moves on the same
    // edge, so a new block enters while the previous one is still emitting.

    logic [1:0]       codec;
    logic [DIM_W-1:0] image_width;
    logic [DIM_W-1:0] image_height;

    bcd_cfg_regs u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .codec        (codec),
        .image_width  (image_width),
        .image_height (image_height)
    );

    // ---- block position tracking (advanced at every input transfer) ----
    logic [POS_W-1:0] col_reg;
    logic [POS_W-1:0] col_next;
    logic [POS_W-1:0] row_reg;
    logic [POS_W-1:0] row_next;
    logic [DIM_W-1:0] w_eff;
    logic [DIM_W-1:0] h_eff;
    logic [DIM_W:0]   wsum;
    logic [DIM_W:0]   hsum;
    logic [11:0]      bx_count;
    logic [11:0]      by_count;
    logic [11:0]      col_inc;
    logic [11:0]      row_inc;
    logic             col_wrap;
    logic             row_wrap;
    block_meta_t      meta_in;

    // saturate dimensions to 1..MAX_DIMENSION
    assign w_eff = (image_width == '0) ? DIM_W'(1) :
                   (image_width > DIM_W'(MAX_DIMENSION)) ? DIM_W'(MAX_DIMENSION) : image_width;
    assign h_eff = (image_height == '0) ? DIM_W'(1) :
                   (image_height > DIM_W'(MAX_DIMENSION)) ? DIM_W'(MAX_DIMENSION) : image_height;

    assign wsum     = {1'b0, w_eff} + (DIM_W+1)'(3);
    assign hsum     = {1'b0, h_eff} + (DIM_W+1)'(3);
    assign bx_count = 12'(wsum[DIM_W:2]);
    assign by_count = 12'(hsum[DIM_W:2]);
    assign col_inc  = {2'b00, col_reg} + 12'd1;
    assign row_inc  = {2'b00, row_reg} + 12'd1;
    assign col_wrap = col_inc >= bx_count;
    assign row_wrap = row_inc >= by_count;

    always_comb
    begin
        meta_in.col       = col_reg;
        meta_in.row       = row_reg;
        meta_in.width     = w_eff;
        meta_in.height    = h_eff;
        meta_in.codec     = codec_t'(codec);
        meta_in.final_blk = (col_inc == bx_count) && (row_inc == by_count);
        meta_in.wrap      = col_wrap && row_wrap;
    end

    // ---- stage handshakes ----
    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic        s2_valid_reg;
    logic        s2_valid_next;
    logic        s1_move;
    logic        s2_move;
    logic        s3_ready;
    logic        blk_take;
    block_t      s1_blk_reg;
    block_meta_t s1_meta_reg;
    block_t      s2_blk_reg;
    block_meta_t s2_meta_reg;

    assign s2_move   = s2_valid_reg && s3_ready;
    assign s1_move   = s1_valid_reg && (!s2_valid_reg || s2_move);
    assign blk_stall = s1_valid_reg && !s1_move;
    assign blk_take  = blk_valid && !blk_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (s1_move)
            s1_valid_next = 1'b0;
        if (blk_take)
            s1_valid_next = 1'b1;

        s2_valid_next = s2_valid_reg;
        if (s2_move)
            s2_valid_next = 1'b0;
        if (s1_move)
            s2_valid_next = 1'b1;

        col_next = col_reg;
        row_next = row_reg;
        if (blk_take)
        begin
            if (col_wrap)
            begin
                col_next = '0;
                row_next = row_wrap ? '0 : row_inc[POS_W-1:0];
            end
            else
            begin
                col_next = col_inc[POS_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            col_reg      <= '0;
            row_reg      <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (blk_take)
        begin
            s1_blk_reg  <= blk;
            s1_meta_reg <= meta_in;
        end
        if (s1_move)
        begin
            s2_blk_reg  <= s1_blk_reg;
            s2_meta_reg <= s1_meta_reg;
        end
    end

    // ---- palettes (register sits between stage 1 and stage 2) ----
    rgb_t [3:0]      cpal;
    logic            punch;
    logic [7:0][7:0] apal;

    bcd_palette u_palette (
        .clk   (clk),
        .load  (s1_move),
        .blk   (s1_blk_reg),
        .codec (s1_meta_reg.codec),
        .cpal  (cpal),
        .punch (punch),
        .apal  (apal)
    );

    // ---- sixteen pixel lanes ----
    rgba_t [LANES-1:0] lane_px;
    logic  [LANES-1:0] lane_in;

    for (genvar i = 0; i < LANES; i++)
    begin : g_lane
        bcd_lane u_lane (
            .lane_idx (4'(i)),
            .meta     (s2_meta_reg),
            .cpal     (cpal),
            .punch    (punch),
            .apal     (apal),
            .cidx     (s2_blk_reg.color_data[32 + 2*i +: 2]),
            .nib      (s2_blk_reg.alpha_block[4*i +: 4]),
            .aidx     (s2_blk_reg.alpha_block[16 + 3*i +: 3]),
            .px       (lane_px[i]),
            .in_image (lane_in[i])
        );
    end

    // ---- merge: serialize in-image pixels, sticky alpha flag ----
    bcd_emitter u_emitter (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (s2_valid_reg),
        .load_ready (s3_ready),
        .load_meta  (s2_meta_reg),
        .load_px    (lane_px),
        .load_mask  (lane_in),
        .pix_valid  (pix_valid),
        .pix_stall  (pix_stall),
        .pix        (pix)
    );

endmodule

// ===== dv/testbench.sv =====
// Testbench for bc1_bc2_bc3_block_decoder: directed and random blocks in every codec and many
// image sizes, each pixel checked field by field by a scoreboard class with its own decoder.
// Depends on bcd_pkg and the decoder RTL.
`timescale 1ns / 1ps

module testbench;
    import bcd_pkg::*;

    // codec register value that the block has no name for; it decodes as BC3
    localparam logic [1:0] CODEC_SPARE = 2'd3;

    localparam int IDLE_MAX         = 19;    // longest gap / stall drawn per transfer
    localparam int DRAIN_CYCLES     = 12;    // pipeline is 3 deep; a block with no pixels
                                             // still passes through the emitter
    localparam int QUIET_LIMIT      = 2000;  // cycles with no transfer before giving up
    localparam int SATURATED_BLOCKS = 16;
    localparam int RANDOM_BLOCKS    = 270;

    // color indices 0,1,2,3 repeated over the 16 pixels
    localparam logic [31:0] COLOR_IDX_RAMP = 32'hE4E4E4E4;
    // 3-bit alpha indices 0..7 repeated over the 16 pixels
    localparam logic [47:0] ALPHA_IDX_RAMP = 48'hFAC688FAC688;

    // ------------------------------------------------------------------
    // Scoreboard: own copy of registers and block position, decodes each
    // accepted block into the pixels it must produce, then matches them.
    // ------------------------------------------------------------------
    class pixel_scoreboard;
        logic [1:0]  codec      = CODEC_BC1;
        logic [12:0] width_reg  = 13'd1;
        logic [12:0] height_reg = 13'd1;
        int unsigned blk_col    = 0;
        int unsigned blk_row    = 0;
        bit          translucent = 1'b0;
        pixel_t      pending_pixels[$];
        int          mismatches = 0;

        function void set_register(logic [1:0] idx, logic [31:0] value);
            case (idx)
                REG_CODEC:  codec      = value[1:0];
                REG_WIDTH:  width_reg  = value[12:0];
                REG_HEIGHT: height_reg = value[12:0];
                default: ;
            endcase
        endfunction

        function int unsigned clamp_dim(logic [12:0] v);
            if (v == 0)
                return 1;
            if (v > MAX_DIMENSION)
                return MAX_DIMENSION;
            return v;
        endfunction

        function rgb_t widen_565(logic [15:0] c);
            rgb_t o;
            o.r = {c[15:11], c[15:13]};
            o.g = {c[10:5], c[10:9]};
            o.b = {c[4:0], c[4:2]};
            return o;
        endfunction

        function void predict_pixels(block_t b);
            int unsigned w, h, cols, rows, x, y, ci, a, a0, a1, i, k;
            int unsigned cpal[4][3];
            int unsigned cpal_alpha[4];
            int unsigned apal[8];
            logic [15:0] c0, c1;
            rgb_t        e0, e1;
            bit          final_blk;
            pixel_t      px;
            pixel_t      blk_pixels[$];

            w    = clamp_dim(width_reg);
            h    = clamp_dim(height_reg);
            cols = (w + 3) / 4;
            rows = (h + 3) / 4;
            final_blk = (blk_col == cols - 1) && (blk_row == rows - 1);

            // color palette
            c0 = b.color_data[15:0];
            c1 = b.color_data[31:16];
            e0 = widen_565(c0);
            e1 = widen_565(c1);
            cpal[0] = '{e0.r, e0.g, e0.b};
            cpal[1] = '{e1.r, e1.g, e1.b};
            cpal_alpha = '{255, 255, 255, 255};
            if (codec == CODEC_BC1 && c0 <= c1)
            begin
                // punch-through: midpoint plus transparent black
                for (k = 0; k < 3; k++)
                begin
                    cpal[2][k] = (cpal[0][k] + cpal[1][k]) / 2;
                    cpal[3][k] = 0;
                end
                cpal_alpha[3] = 0;
            end
            else
            begin
                for (k = 0; k < 3; k++)
                begin
                    cpal[2][k] = (2 * cpal[0][k] + cpal[1][k]) / 3;
                    cpal[3][k] = (cpal[0][k] + 2 * cpal[1][k]) / 3;
                end
            end

            // BC3 alpha palette, rounded to nearest
            a0 = b.alpha_block[7:0];
            a1 = b.alpha_block[15:8];
            apal[0] = a0;
            apal[1] = a1;
            if (a0 > a1)
            begin
                for (k = 1; k <= 6; k++)
                    apal[k + 1] = ((7 - k) * a0 + k * a1 + 3) / 7;
            end
            else
            begin
                for (k = 1; k <= 4; k++)
                    apal[k + 1] = ((5 - k) * a0 + k * a1 + 2) / 5;
                apal[6] = 0;
                apal[7] = 255;
            end

            for (i = 0; i < 16; i++)
            begin
                x = blk_col * 4 + (i % 4);
                y = blk_row * 4 + (i / 4);
                if (x >= w || y >= h)
                    continue;
                ci = b.color_data[32 + 2 * i +: 2];
                if (codec == CODEC_BC1)
                    a = cpal_alpha[ci];
                else if (codec == CODEC_BC2)
                    a = b.alpha_block[4 * i +: 4] * 17;
                else
                    a = apal[b.alpha_block[16 + 3 * i +: 3]];
                if (a < 255)
                    translucent = 1'b1;
                px.pixel_x       = 12'(x);
                px.pixel_y       = 12'(y);
                px.red           = 8'(cpal[ci][0]);
                px.green         = 8'(cpal[ci][1]);
                px.blue          = 8'(cpal[ci][2]);
                px.alpha         = 8'(a);
                px.last_of_block = 1'b0;
                px.last_of_image = 1'b0;
                px.alpha_seen    = translucent;
                blk_pixels.push_back(px);
            end

            if (blk_pixels.size() > 0)
            begin
                blk_pixels[blk_pixels.size() - 1].last_of_block = 1'b1;
                blk_pixels[blk_pixels.size() - 1].last_of_image = final_blk;
            end
            foreach (blk_pixels[n])
                pending_pixels.push_back(blk_pixels[n]);

            // raster advance; the sticky flag clears when the image wraps
            blk_col++;
            if (blk_col >= cols)
            begin
                blk_col = 0;
                blk_row++;
                if (blk_row >= rows)
                begin
                    blk_row = 0;
                    translucent = 1'b0;
                end
            end
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            mismatches++;
        endtask

        task compare_field(string name, int unsigned got, int unsigned want, pixel_t exp_px);
            if (got != want)
                report_mismatch($sformatf("%s of pixel (%0d,%0d): got %0d, expected %0d",
                                          name, exp_px.pixel_x, exp_px.pixel_y, got, want));
        endtask

        task check_pixel(pixel_t got);
            pixel_t want;
            if (pending_pixels.size() == 0)
            begin
                report_mismatch($sformatf("pixel (%0d,%0d) arrived with none expected",
                                          got.pixel_x, got.pixel_y));
                return;
            end
            want = pending_pixels.pop_front();
            compare_field("pixel_x", got.pixel_x, want.pixel_x, want);
            compare_field("pixel_y", got.pixel_y, want.pixel_y, want);
            compare_field("red", got.red, want.red, want);
            compare_field("green", got.green, want.green, want);
            compare_field("blue", got.blue, want.blue, want);
            compare_field("alpha", got.alpha, want.alpha, want);
            compare_field("last_of_block", got.last_of_block, want.last_of_block, want);
            compare_field("last_of_image", got.last_of_image, want.last_of_image, want);
            compare_field("alpha_seen", got.alpha_seen, want.alpha_seen, want);
        endtask
    endclass

    // ------------------------------------------------------------------
    // DUT and its signals
    // ------------------------------------------------------------------
    logic        clk = 1'b0;
    logic        rst_n;
    logic        blk_valid;
    logic        blk_stall;
    block_t      blk;
    logic        pix_valid;
    logic        pix_stall;
    pixel_t      pix;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    pixel_scoreboard pixel_check = new;

    int tx_max = 0;        // longest gap the block sender draws in this phase
    int rx_max = 0;        // longest stall the pixel receiver draws in this phase
    int quiet_cycles = 0;

    bc1_bc2_bc3_block_decoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .blk_valid (blk_valid),
        .blk_stall (blk_stall),
        .blk       (blk),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix       (pix),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // APB write: setup cycle, then access cycle; the register takes the
    // value at the edge where the access phase meets pready. Then psel
    // drops, so back-to-back writes never touch psel twice in a step.
    task apb_write(logic [1:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        pixel_check.set_register(idx, value);
        @(posedge clk);
    endtask

    // Writes all three registers; unused upper data bits sometimes carry junk,
    // which the block must drop.
    task configure(logic [1:0] codec, logic [12:0] width, logic [12:0] height);
        logic [31:0] junk;
        junk = ($urandom_range(0, 1) == 1) ? $urandom : 32'd0;
        apb_write(REG_CODEC, {junk[31:2], codec});
        apb_write(REG_WIDTH, {junk[31:13], width});
        apb_write(REG_HEIGHT, {junk[31:13], height});
    endtask

    // One block transfer after a random gap. Valid stays up across
    // back-to-back transfers; the payload only changes once accepted.
    task send_block(block_t b);
        int gap;
        gap = (tx_max == 0) ? 0 : $urandom_range(0, tx_max);
        if (gap > 0)
        begin
            blk_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        blk_valid <= 1'b1;
        blk       <= b;
        do
            @(posedge clk);
        while (!(blk_valid && !blk_stall));
        pixel_check.predict_pixels(b);
    endtask

    // Quiet the input side and wait until every predicted pixel has come out,
    // plus a margin for a trailing block that emits nothing.
    task settle();
        blk_valid <= 1'b0;
        while (pixel_check.pending_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Random content, steered so both palette modes of each codec show up
    // in roughly equal share, with equal endpoints now and then.
    function block_t random_block(logic [1:0] codec);
        logic [63:0] cb;
        logic [63:0] ab;
        logic [15:0] tc;
        logic [7:0]  ta;
        cb = {$urandom, $urandom};
        ab = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0: cb[31:16] = cb[15:0];
            1, 2, 3:
                if (cb[15:0] > cb[31:16])
                begin
                    tc = cb[15:0]; cb[15:0] = cb[31:16]; cb[31:16] = tc;
                end
            default:
                if (cb[15:0] < cb[31:16])
                begin
                    tc = cb[15:0]; cb[15:0] = cb[31:16]; cb[31:16] = tc;
                end
        endcase
        if (codec == CODEC_BC2)
        begin
            if ($urandom_range(0, 3) == 0)
                ab = '1;                      // fully opaque block
        end
        else
        begin
            case ($urandom_range(0, 7))
                0: ab[15:8] = ab[7:0];
                1, 2, 3:
                    if (ab[7:0] > ab[15:8])
                    begin
                        ta = ab[7:0]; ab[7:0] = ab[15:8]; ab[15:8] = ta;
                    end
                default:
                    if (ab[7:0] < ab[15:8])
                    begin
                        ta = ab[7:0]; ab[7:0] = ab[15:8]; ab[15:8] = ta;
                    end
            endcase
        end
        return {cb, ab};
    endfunction

    task send_random_blocks(int count, logic [1:0] codec);
        repeat (count) send_block(random_block(codec));
    endtask

    // Mostly small images; sometimes zero (saturates to 1) or anything larger.
    function logic [12:0] pick_dim();
        case ($urandom_range(0, 9))
            0:       return 13'd0;
            1:       return 13'($urandom_range(17, 8191));
            default: return 13'($urandom_range(1, 16));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        logic [1:0]  codec_v;
        logic [12:0] width_v;
        logic [12:0] height_v;
        int unsigned per_image;
        int          count;
        int          random_sent;

        rst_n     <= 1'b0;
        blk_valid <= 1'b0;
        blk       <= '0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        random_sent = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: BC1, 8x8 = one image of four blocks; all-zero, all-one,
        // four-color mode and punch-through mode with every index.
        tx_max = IDLE_MAX;
        rx_max = 0;
        configure(CODEC_BC1, 13'd8, 13'd8);
        send_block({64'h0, 64'h0});
        send_block({64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF});
        send_block({COLOR_IDX_RAMP, 16'h1234, 16'hF81F, 64'h0});
        send_block({COLOR_IDX_RAMP, 16'hF81F, 16'h1234, 64'h0});
        settle();

        // BC2: explicit alpha ramp, opaque, fully clear; c0 <= c1 stays four-color
        tx_max = 0;
        rx_max = IDLE_MAX;
        configure(CODEC_BC2, 13'd8, 13'd8);
        send_block({COLOR_IDX_RAMP, 16'h001F, 16'h07E0, 64'hFEDC_BA98_7654_3210});
        send_block({COLOR_IDX_RAMP, 16'hFFFF, 16'h0000, 64'hFFFF_FFFF_FFFF_FFFF});
        send_block({COLOR_IDX_RAMP, 16'h8410, 16'h8410, 64'h0});
        send_block({32'h1B1B1B1B, 16'h0000, 16'hFFFF, 64'h0123_4567_89AB_CDEF});
        settle();

        // BC3: eight-entry palette, six-entry plus 0/255, equal endpoints, extremes
        tx_max = IDLE_MAX;
        configure(CODEC_BC3, 13'd8, 13'd8);
        send_block({COLOR_IDX_RAMP, 16'hF800, 16'h07E0, ALPHA_IDX_RAMP, 8'h10, 8'hF0});
        send_block({COLOR_IDX_RAMP, 16'hF800, 16'h07E0, ALPHA_IDX_RAMP, 8'hF0, 8'h10});
        send_block({COLOR_IDX_RAMP, 16'hF800, 16'h07E0, ALPHA_IDX_RAMP, 8'h80, 8'h80});
        send_block({COLOR_IDX_RAMP, 16'hF800, 16'h07E0, ALPHA_IDX_RAMP, 8'h00, 8'hFF});
        settle();

        // unused codec value decodes as BC3; 5x3 clips the right block to one column
        configure(CODEC_SPARE, 13'd5, 13'd3);
        send_random_blocks(4, CODEC_SPARE);
        settle();

        // zero dimensions saturate to a single pixel
        configure(CODEC_BC1, 13'd0, 13'd0);
        send_random_blocks(2, CODEC_BC1);
        settle();

        // Width above the maximum saturates, then a tall image entered
        // mid-row: the leftover column lies outside and wraps to the next row.
        tx_max = 0;
        rx_max = 0;
        configure(CODEC_BC2, 13'd8191, 13'd0);
        send_random_blocks(SATURATED_BLOCKS, CODEC_BC2);
        settle();
        configure(CODEC_SPARE, 13'd1, 13'd4096);
        send_random_blocks(SATURATED_BLOCKS, CODEC_SPARE);
        settle();

        // Random phases. Block counts are usually whole images plus a few,
        // so the next configuration often lands mid-image and some blocks
        // fall outside the new image.
        while (random_sent < RANDOM_BLOCKS)
        begin
            codec_v  = 2'($urandom_range(0, 3));
            width_v  = pick_dim();
            height_v = pick_dim();
            tx_max   = ($urandom_range(0, 3) == 0) ? 0 : IDLE_MAX;
            rx_max   = ($urandom_range(0, 3) == 0) ? 0 : IDLE_MAX;
            per_image = ((pixel_check.clamp_dim(width_v) + 3) / 4) *
                        ((pixel_check.clamp_dim(height_v) + 3) / 4);
            if (per_image <= 32)
                count = per_image * $urandom_range(1, 2) + $urandom_range(0, 2);
            else
                count = $urandom_range(4, 24);
            configure(codec_v, width_v, height_v);
            send_random_blocks(count, codec_v);
            settle();
            random_sent += count;
        end

        if (pixel_check.mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Pixel receiver: before each transfer it holds stall for a random count.
    initial
    begin
        int hold;
        pix_stall <= 1'b0;
        @(posedge clk);
        forever
        begin
            hold = (rx_max == 0) ? 0 : $urandom_range(0, rx_max);
            if (hold > 0)
            begin
                pix_stall <= 1'b1;
                repeat (hold) @(posedge clk);
                pix_stall <= 1'b0;
            end
            do
                @(posedge clk);
            while (!(pix_valid && !pix_stall));
        end
    end

    // Pixel monitor: every output transfer goes to the scoreboard.
    always @(posedge clk)
    begin
        if (rst_n && pix_valid && !pix_stall)
            pixel_check.check_pixel(pix);
    end

    // Watchdog: too long without a transfer on either side means a hang.
    always @(posedge clk)
    begin
        if (!rst_n || (blk_valid && !blk_stall) || (pix_valid && !pix_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

endmodule
